FILE: sv/txc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txc_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package txc_pkg;

	localparam int COLS       = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLS * ROWS;
	localparam int MOVE_COUNT = COLS * (ROWS - 1);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [7:0] NEWLINE_CODE       = 8'd10;
	localparam logic [7:0] RESET_DEFAULT_ATTR = 8'h0f;
	localparam logic [7:0] RESET_ERROR_CHAR   = 8'd69;
	localparam logic [7:0] RESET_ERROR_ATTR   = 8'hf4;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_CHAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_DRAIN,
		ST_FINISH
	} txc_state_t;

	// Linear cell index of a row and column on the screen.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col));
	endfunction

endpackage
`default_nettype wire

FILE: sv/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen store with a hardware cursor, scrolling and cell read.
// ----------------------------------------------------------------------------
// A put or a read request is taken in the idle cycle; its result is loaded into
// the output register in the finish state, once the old result has been taken.
// A put that runs past the last cell also scrolls: one cell of the screen
// store is moved or cleared per cycle, then a drain state ends the scroll.
// Reset sets the registers and the cursor (top left), then a clearing pass
// zeroes all CELL_COUNT (2000) cells; requests wait, configuration writes do not.
module text_console_writer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [txc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [txc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// char_code[7:0], attribute[15:8], use_cursor[16], column[23:17], line[28:24]
	input  wire logic [31:0] s_tdata,
	// operation[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// cursor_column[6:0], cursor_line[11:7], position_error[12], scrolled[13],
	// cell_char[21:14], cell_attribute[29:22]
	output logic [31:0]      m_tdata
);

	localparam int AW = txc_pkg::ADDR_W;
	localparam int CW = txc_pkg::COL_W;
	localparam int RW = txc_pkg::ROW_W;

	txc_pkg::txc_state_t state_q, state_d;

	logic [15:0]   mem [txc_pkg::CELL_COUNT];
	logic [15:0]   rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;

	logic [7:0]    default_attr_q, error_char_q, error_attr_q;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [RW-1:0] cur_row_q, cur_row_d;
	logic          perr_q, perr_d, scrolled_q, scrolled_d, hit_q, hit_d;
	logic [AW-1:0] scan_q, scan_d;
	logic          pend_s1, pend_zero_s1;
	logic [AW-1:0] pend_addr_s1;
	logic          m_tvalid_q, load_out;
	logic [31:0]   m_tdata_q;

	logic          in_op, in_uc, bad_pos, advance, last_row, accept, scan_last;
	logic [7:0]    in_ch, in_at, attr_eff;
	logic [CW-1:0] in_col, pos_col;
	logic [RW-1:0] in_row, pos_row;

	assign in_op  = s_tuser[0];
	assign in_ch  = s_tdata[7:0];
	assign in_at  = s_tdata[15:8];
	assign in_uc  = s_tdata[16];
	assign in_col = s_tdata[23:17];
	assign in_row = s_tdata[28:24];

	assign s_tready  = (state_q == txc_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign scan_last = (scan_q == AW'(txc_pkg::CELL_COUNT - 1));

	assign bad_pos  = (in_col >= CW'(txc_pkg::COLS)) || (in_row >= RW'(txc_pkg::ROWS));
	assign pos_col  = in_uc ? cur_col_q : in_col;
	assign pos_row  = in_uc ? cur_row_q : in_row;
	assign attr_eff = (in_at == 8'd0) ? default_attr_q : in_at;
	assign advance  = (in_ch == txc_pkg::NEWLINE_CODE) ||
		(pos_col == CW'(txc_pkg::COLS - 1));
	assign last_row = (pos_row == RW'(txc_pkg::ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= txc_pkg::RESET_DEFAULT_ATTR;
			error_char_q   <= txc_pkg::RESET_ERROR_CHAR;
			error_attr_q   <= txc_pkg::RESET_ERROR_ATTR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				txc_pkg::REG_DEFAULT_ATTR: default_attr_q <= cfg_data;
				txc_pkg::REG_ERROR_CHAR:   error_char_q   <= cfg_data;
				txc_pkg::REG_ERROR_ATTR:   error_attr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= txc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		perr_d     = perr_q;
		scrolled_d = scrolled_q;
		hit_d      = hit_q;
		scan_d     = scan_q;
		load_out   = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = scan_q;
		mem_wd     = 16'd0;
		mem_re     = 1'b0;
		mem_ra     = txc_pkg::cell_addr(in_row, in_col);
		unique case (state_q)
			txc_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				scan_d = scan_last ? AW'(0) : AW'(scan_q + AW'(1));
				if (scan_last) begin
					state_d = txc_pkg::ST_IDLE;
				end
			end
			txc_pkg::ST_IDLE: begin
				if (accept) begin
					perr_d     = 1'b0;
					scrolled_d = 1'b0;
					hit_d      = 1'b0;
					state_d    = txc_pkg::ST_FINISH;
					if (in_op == txc_pkg::OP_READ) begin
						perr_d = bad_pos;
						hit_d  = !bad_pos;
						mem_re = !bad_pos;
					end else if (!in_uc && bad_pos) begin
						perr_d = 1'b1;
						mem_we = 1'b1;
						mem_wa = AW'(txc_pkg::CELL_COUNT - 1);
						mem_wd = {error_attr_q, error_char_q};
					end else begin
						if (in_ch != txc_pkg::NEWLINE_CODE) begin
							mem_we = 1'b1;
							mem_wa = txc_pkg::cell_addr(pos_row, pos_col);
							mem_wd = {attr_eff, in_ch};
						end
						cur_col_d = advance ? CW'(0) : CW'(pos_col + CW'(1));
						cur_row_d = (advance && !last_row) ? RW'(pos_row + RW'(1)) : pos_row;
						if (advance && last_row) begin
							scrolled_d = 1'b1;
							state_d    = txc_pkg::ST_SCROLL;
						end
					end
				end
			end
			txc_pkg::ST_SCROLL: begin
				// Rows move up one cell a cycle; the read runs a row ahead of the write.
				mem_re = (scan_q < AW'(txc_pkg::MOVE_COUNT));
				mem_ra = AW'(scan_q + AW'(txc_pkg::COLS));
				scan_d = scan_last ? AW'(0) : AW'(scan_q + AW'(1));
				if (scan_last) begin
					state_d = txc_pkg::ST_DRAIN;
				end
			end
			txc_pkg::ST_DRAIN: begin
				state_d = txc_pkg::ST_FINISH;
			end
			txc_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = txc_pkg::ST_IDLE;
				end
			end
			default: state_d = txc_pkg::ST_IDLE;
		endcase
		if (pend_s1) begin
			mem_we = 1'b1;
			mem_wa = pend_addr_s1;
			mem_wd = pend_zero_s1 ? 16'd0 : rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			perr_q     <= 1'b0;
			scrolled_q <= 1'b0;
			hit_q      <= 1'b0;
			scan_q     <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cur_col_q  <= cur_col_d;
			cur_row_q  <= cur_row_d;
			perr_q     <= perr_d;
			scrolled_q <= scrolled_d;
			hit_q      <= hit_d;
			scan_q     <= scan_d;
			pend_s1    <= (state_q == txc_pkg::ST_SCROLL);
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= scan_q;
		pend_zero_s1 <= (scan_q >= AW'(txc_pkg::MOVE_COUNT));
		if (load_out) begin
			m_tdata_q <= {2'b00,
				hit_q ? rd_q[15:8] : 8'd0,
				hit_q ? rd_q[7:0] : 8'd0,
				scrolled_q, perr_q, cur_row_q, cur_col_q};
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q < CW'(txc_pkg::COLS)) && (cur_row_q < RW'(txc_pkg::ROWS)))
		else $error("cursor left the screen");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == txc_pkg::ST_FINISH && (!m_tvalid_q || m_tready)) |=> m_tvalid_q)
		else $error("finished request produced no result");

	a_move_write_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == txc_pkg::ST_SCROLL || state_q == txc_pkg::ST_DRAIN))
		else $error("scroll write outside a scroll");

endmodule
`default_nettype wire
